[rtl/lst_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lst_pkg: shared widths and constants for the latency statistics tracker
// Field widths, warm-up length, the half-millisecond limit and command codes.
// ----------------------------------------------------------------------------
package lst_pkg;

	localparam int unsigned DurW   = 40;   // durations and averages, ns
	localparam int unsigned CountW = 24;   // saturating sample counts
	localparam int unsigned SumW   = 64;   // saturating duration sums

	localparam logic [CountW-1:0] WarmupSamples = CountW'(60);
	localparam logic [DurW-1:0]   HalfMsNs      = DurW'(500000);

	typedef enum logic {
		CMD_RECORD = 1'b0,
		CMD_CLEAR  = 1'b1
	} lst_cmd_t;

	typedef logic [DurW-1:0]   dur_t;
	typedef logic [CountW-1:0] count_t;
	typedef logic [SumW-1:0]   sum_t;

endpackage

`default_nettype wire

[rtl/lst_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lst_if: valid/ready channels of the latency statistics tracker
// lst_sample_if carries commands and durations in, lst_stats_if results out.
// ----------------------------------------------------------------------------
interface lst_sample_if
	import lst_pkg::*;
();
	logic     valid;
	logic     ready;
	lst_cmd_t command;
	dur_t     elapsed_ns;

	modport source (output valid, output command, output elapsed_ns, input ready);
	modport sink   (input valid, input command, input elapsed_ns, output ready);
endinterface

interface lst_stats_if
	import lst_pkg::*;
();
	logic   valid;
	logic   ready;
	dur_t   elapsed_echo_ns;
	count_t sample_count;
	dur_t   average_ns;
	logic   above_flag;
	count_t above_count;
	dur_t   above_average_ns;
	dur_t   above_max_ns;

	modport source (
		output valid, output elapsed_echo_ns, output sample_count, output average_ns,
		output above_flag, output above_count, output above_average_ns,
		output above_max_ns, input ready
	);
	modport sink (
		input valid, input elapsed_echo_ns, input sample_count, input average_ns,
		input above_flag, input above_count, input above_average_ns,
		input above_max_ns, output ready
	);
endinterface

`default_nettype wire

[rtl/latency_statistics_tracker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// latency_statistics_tracker: running and outlier latency statistics
// Counts, sums and averages measured durations; flags and tracks outliers.
// ----------------------------------------------------------------------------
// Usage:
//   sample (sink): one transaction per measured duration (command RECORD) or
//     a clear of all trackers (command CLEAR). ready is high only while the
//     sequencer is idle.
//   stats (source): exactly one transaction per sample transaction, carrying
//     the echoed duration, the outlier flag and all tracker values after it.
//   cfg_wr_en / cfg_wr_data: writes the 40-bit outlier limit. Write only
//     while the block is idle. Above 500000 ns the limit is fixed; below it,
//     the rule is "more than twice the running average"; at it, none applies.
// Sequence: a clear or a warm-up sample (first 60) goes from the update
//   step to the output register. A later sample runs one 40-step division,
//   an outlier a second one (a quotient that would overflow is saturated).
//   Both divisions share one restoring radix-2 divider, one quotient bit a
//   cycle; a new sample is taken only after the last one is finished.
// Reset: arst_n clears all trackers, the limit and the output valid.
// Stall: the finished result sits in an output register. While it is not
//   taken, the next sample runs to the last step and holds there (ready low).
// ----------------------------------------------------------------------------
module latency_statistics_tracker
	import lst_pkg::*;
(
	input  wire  logic  clk,
	input  wire  logic  arst_n,
	input  wire  logic  cfg_wr_en,
	input  wire  dur_t  cfg_wr_data,
	lst_sample_if.sink  sample,
	lst_stats_if.source stats
);

	localparam int unsigned StepW = $clog2(DurW);
	localparam logic [StepW-1:0] LastStep = StepW'(DurW - 1);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_ACC  = 9'b000000010,   // update count and sum, or clear
		ST_LD1  = 9'b000000100,   // load divider: sum / count
		ST_DV1  = 9'b000001000,
		ST_TEST = 9'b000010000,   // store mean, outlier test, outlier update
		ST_LD2  = 9'b000100000,   // load divider: outlier sum / outlier count
		ST_DV2  = 9'b001000000,
		ST_WR2  = 9'b010000000,   // store outlier mean
		ST_FIN  = 9'b100000000    // hand result to output register
	} lst_state_t;

	lst_state_t st_q;

	// configuration
	dur_t limit_q;

	// captured transaction
	lst_cmd_t cmd_q;
	dur_t     t_q;
	logic     above_q;

	// trackers
	count_t total_q;
	sum_t   sum_q;
	dur_t   mean_q;
	count_t otot_q;
	sum_t   osum_q;
	dur_t   omean_q;
	dur_t   peak_q;

	// shared divider: remainder, dividend/quotient shift register, divisor
	count_t          rem_q;
	dur_t            dvd_q;
	count_t          dsr_q;
	logic [StepW-1:0] step_q;

	// output register
	logic   res_valid_q;
	dur_t   res_echo_q;
	count_t res_count_q;
	dur_t   res_avg_q;
	logic   res_above_q;
	count_t res_acount_q;
	dur_t   res_aavg_q;
	dur_t   res_amax_q;

	// ---- combinational helpers ----
	count_t          total_inc;
	logic [SumW:0]   sum_add;
	sum_t            sum_sat;
	count_t          otot_inc;
	logic [SumW:0]   osum_add;
	sum_t            osum_sat;
	sum_t            ld_sum;
	count_t          ld_div;
	logic            ld_ovf;
	logic [CountW:0] trial;
	logic            trial_ge;
	logic            is_above;
	logic            out_free;

	assign total_inc = (total_q == '1) ? total_q : total_q + CountW'(1);
	assign sum_add   = {1'b0, sum_q} + {{(SumW + 1 - DurW){1'b0}}, t_q};
	assign sum_sat   = sum_add[SumW] ? '1 : sum_add[SumW-1:0];
	assign otot_inc  = (otot_q == '1) ? otot_q : otot_q + CountW'(1);
	assign osum_add  = {1'b0, osum_q} + {{(SumW + 1 - DurW){1'b0}}, t_q};
	assign osum_sat  = osum_add[SumW] ? '1 : osum_add[SumW-1:0];

	// divider operand select; quotient overflows 40 bits when high part >= divisor
	assign ld_sum = (st_q == ST_LD2) ? osum_q : sum_q;
	assign ld_div = (st_q == ST_LD2) ? otot_q : total_q;
	assign ld_ovf = ld_sum[SumW-1:DurW] >= ld_div;

	assign trial    = {rem_q, dvd_q[DurW-1]};
	assign trial_ge = trial >= {1'b0, dsr_q};

	// outlier rule, against the freshly divided mean in dvd_q
	always_comb begin
		if (limit_q > HalfMsNs) begin
			is_above = t_q > limit_q;
		end else if (limit_q < HalfMsNs) begin
			is_above = {1'b0, t_q} > {dvd_q, 1'b0};
		end else begin
			is_above = 1'b0;
		end
	end

	assign out_free     = !res_valid_q || stats.ready;
	assign sample.ready = (st_q == ST_IDLE);

	// ---- sequencer and datapath ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			limit_q <= '0;
			total_q <= '0;
			sum_q   <= '0;
			mean_q  <= '0;
			otot_q  <= '0;
			osum_q  <= '0;
			omean_q <= '0;
			peak_q  <= '0;
			step_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			case (st_q)
				ST_IDLE: begin
					if (sample.valid) begin
						st_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (cmd_q == CMD_CLEAR) begin
						total_q <= '0;
						sum_q   <= '0;
						mean_q  <= '0;
						otot_q  <= '0;
						osum_q  <= '0;
						omean_q <= '0;
						peak_q  <= '0;
						st_q    <= ST_FIN;
					end else begin
						total_q <= total_inc;
						sum_q   <= sum_sat;
						st_q    <= (total_inc > WarmupSamples) ? ST_LD1 : ST_FIN;
					end
				end
				ST_LD1, ST_LD2: begin
					step_q <= '0;
					if (ld_ovf) begin
						st_q <= (st_q == ST_LD1) ? ST_TEST : ST_WR2;
					end else begin
						st_q <= (st_q == ST_LD1) ? ST_DV1 : ST_DV2;
					end
				end
				ST_DV1, ST_DV2: begin
					step_q <= step_q + StepW'(1);
					if (step_q == LastStep) begin
						st_q <= (st_q == ST_DV1) ? ST_TEST : ST_WR2;
					end
				end
				ST_TEST: begin
					mean_q <= dvd_q;
					if (is_above) begin
						otot_q <= otot_inc;
						osum_q <= osum_sat;
						if (t_q > peak_q) begin
							peak_q <= t_q;
						end
						st_q <= ST_LD2;
					end else begin
						st_q <= ST_FIN;
					end
				end
				ST_WR2: begin
					omean_q <= dvd_q;
					st_q    <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers: capture, divider, outlier flag
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && sample.valid) begin
			cmd_q <= sample.command;
			t_q   <= sample.elapsed_ns;
		end
		if (st_q == ST_ACC) begin
			above_q <= 1'b0;
			if (cmd_q == CMD_CLEAR) begin
				t_q <= '0;
			end
		end
		if (st_q == ST_TEST) begin
			above_q <= is_above;
		end
		if (st_q == ST_LD1 || st_q == ST_LD2) begin
			rem_q <= ld_sum[SumW-1:DurW];
			dvd_q <= ld_ovf ? '1 : ld_sum[DurW-1:0];
			dsr_q <= ld_div;
		end
		if (st_q == ST_DV1 || st_q == ST_DV2) begin
			rem_q <= trial_ge ? CountW'(trial - {1'b0, dsr_q}) : trial[CountW-1:0];
			dvd_q <= {dvd_q[DurW-2:0], trial_ge};
		end
	end

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (st_q == ST_FIN && out_free) begin
			res_valid_q <= 1'b1;
		end else if (stats.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_FIN && out_free) begin
			res_echo_q   <= t_q;
			res_count_q  <= total_q;
			res_avg_q    <= mean_q;
			res_above_q  <= above_q;
			res_acount_q <= otot_q;
			res_aavg_q   <= omean_q;
			res_amax_q   <= peak_q;
		end
	end

	assign stats.valid            = res_valid_q;
	assign stats.elapsed_echo_ns  = res_echo_q;
	assign stats.sample_count     = res_count_q;
	assign stats.average_ns       = res_avg_q;
	assign stats.above_flag       = res_above_q;
	assign stats.above_count      = res_acount_q;
	assign stats.above_average_ns = res_aavg_q;
	assign stats.above_max_ns     = res_amax_q;

`ifndef SYNTHESIS
	// divider never runs past its last quotient bit
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DV1 || st_q == ST_DV2) |-> step_q <= LastStep)
		else $error("divider step out of range");

	// an outlier is only reported after warm-up, and is counted
	a_flag_after_warmup: assert property (@(posedge clk) disable iff (!arst_n)
		(stats.valid && stats.above_flag) |->
			(stats.sample_count > WarmupSamples && stats.above_count != '0))
		else $error("outlier flagged during warm-up or not counted");

	// outlier mean never exceeds the outlier peak
	a_mean_le_peak: assert property (@(posedge clk) disable iff (!arst_n)
		stats.valid |-> stats.above_average_ns <= stats.above_max_ns)
		else $error("outlier mean above outlier peak");

	// a result is loaded only into a free output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !stats.ready) |=> ($stable(res_echo_q) && res_valid_q))
		else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

[sim/tb_latency_statistics_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_latency_statistics_tracker: self-checking bench for the latency tracker
// Sends duration records and clears with bursty traffic and stalls the
// stats channel. Every stats transaction is checked against an in-bench
// model of the running and outlier statistics.
// ----------------------------------------------------------------------------
module tb_latency_statistics_tracker;
	import lst_pkg::*;

	localparam int unsigned ClkHalf     = 5;        // 10 ns period
	localparam int unsigned ResetCycles = 11;
	localparam int unsigned CycleLimit  = 1000000;  // many times the slowest run
	localparam int unsigned RandomItems = 520;
	localparam int unsigned SettleCycles = 100;     // beyond the longest latency
	localparam dur_t        DurMax      = '1;

	// receiver stall styles
	typedef enum int unsigned {
		RX_STEADY,
		RX_RANDOM,
		RX_PATTERN
	} rx_mode_t;

	// one expected stats transaction
	typedef struct {
		dur_t   echo_ns;
		count_t count;
		dur_t   average_ns;
		logic   above;
		count_t above_count;
		dur_t   above_average_ns;
		dur_t   above_max_ns;
	} stats_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	dur_t cfg_wr_data;

	lst_sample_if sample ();
	lst_stats_if  stats ();

	latency_statistics_tracker i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.sample      (sample),
		.stats       (stats)
	);

	always #ClkHalf clk = ~clk;

	// ------------------------------------------------------------------
	// Tracker model: its own copy of the limit and of every tracker.
	// ------------------------------------------------------------------
	dur_t   limit_ns = '0;
	count_t seen_count;
	sum_t   seen_sum;
	dur_t   seen_mean;
	count_t slow_count;
	sum_t   slow_sum;
	dur_t   slow_mean;
	dur_t   slow_peak;

	// expectations in transaction order
	stats_t stats_expected[$];

	// bookkeeping
	int unsigned mismatches = 0;
	int unsigned n_sent     = 0;
	int unsigned n_clears   = 0;
	int unsigned n_flagged  = 0;
	int unsigned n_checked  = 0;
	int unsigned n_limits   = 0;
	int unsigned cycle_count = 0;

	// sender state: offering mirrors the valid we drive (read without races)
	bit          offering   = 1'b0;
	bit          steady     = 1'b0;  // no gaps while set
	int unsigned burst_left = 1;

	// long receiver hold, picked up by the receiver process
	int unsigned hold_request = 0;

	function automatic void drop_statistics();
		seen_count = '0;
		seen_sum   = '0;
		seen_mean  = '0;
		slow_count = '0;
		slow_sum   = '0;
		slow_mean  = '0;
		slow_peak  = '0;
	endfunction

	function automatic sum_t sat_sum(sum_t acc, dur_t ns);
		logic [SumW:0] s;
		s = acc + ns;
		return s[SumW] ? '1 : s[SumW-1:0];
	endfunction

	function automatic count_t sat_count(count_t c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	// whole-ns mean, clamped to the duration width
	function automatic dur_t truncated_mean(sum_t s, count_t c);
		sum_t q;
		if (c == '0)
			return '0;
		q = s / c;
		return (q > sum_t'(DurMax)) ? DurMax : q[DurW-1:0];
	endfunction

	// Apply one sample transaction to the model and return the stats it causes.
	function automatic stats_t track_latency(lst_cmd_t cmd, dur_t ns);
		stats_t r;
		logic   above;
		above = 1'b0;
		if (cmd == CMD_CLEAR) begin
			// clear zeroes every tracker but keeps the limit
			drop_statistics();
			ns = '0;
		end else begin
			seen_count = sat_count(seen_count);
			seen_sum   = sat_sum(seen_sum, ns);
			// nothing moves past the counters during warm-up
			if (seen_count > WarmupSamples) begin
				seen_mean = truncated_mean(seen_sum, seen_count);
				// fixed limit above half a ms, twice the mean below, none at it
				if (limit_ns > HalfMsNs)
					above = ns > limit_ns;
				else if (limit_ns < HalfMsNs)
					above = {1'b0, ns} > {seen_mean, 1'b0};
				if (above) begin
					slow_sum   = sat_sum(slow_sum, ns);
					slow_count = sat_count(slow_count);
					slow_mean  = truncated_mean(slow_sum, slow_count);
					if (ns > slow_peak)
						slow_peak = ns;
				end
			end
		end
		r.echo_ns          = ns;
		r.count            = seen_count;
		r.average_ns       = seen_mean;
		r.above            = above;
		r.above_count      = slow_count;
		r.above_average_ns = slow_mean;
		r.above_max_ns     = slow_peak;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Value generators
	// ------------------------------------------------------------------
	function automatic dur_t rand_dur();
		return dur_t'({$urandom(), $urandom()});
	endfunction

	// magnitude of a sequence: anywhere from a few ns to the full width
	function automatic dur_t pick_scale();
		return rand_dur() >> (DurW - $urandom_range(DurW, 1));
	endfunction

	// mostly near the scale, sometimes a spike, now and then anything
	function automatic dur_t jitter_dur(dur_t scale);
		logic [63:0] half;
		logic [63:0] v;
		half = scale >> 1;
		case ($urandom_range(19, 0))
			0:       v = rand_dur();
			1, 2, 3: v = scale * $urandom_range(5, 2);
			default: v = half + ({$urandom(), $urandom()} % (half + 1));
		endcase
		return (v > 64'(DurMax)) ? DurMax : v[DurW-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Sender: every task returns right after a rising edge.
	// ------------------------------------------------------------------
	task automatic send_item(lst_cmd_t cmd, dur_t ns);
		stats_t want;
		if (!offering) begin
			sample.valid <= 1'b1;
			offering = 1'b1;
		end
		sample.command    <= cmd;
		sample.elapsed_ns <= ns;
		// inputs only move at rising edges, so the falling edge shows
		// the handshake that the next rising edge will see
		@(negedge clk);
		while (!sample.ready)
			@(negedge clk);
		@(posedge clk);
		want = track_latency(cmd, ns);
		stats_expected.push_back(want);
		n_sent++;
		if (cmd == CMD_CLEAR)
			n_clears++;
		if (want.above)
			n_flagged++;
		if (!steady) begin
			if (burst_left > 0)
				burst_left--;
			if (burst_left == 0) begin
				sample.valid <= 1'b0;
				offering = 1'b0;
				repeat ($urandom_range(8, 1)) @(posedge clk);
				burst_left = $urandom_range(24, 1);
			end
		end
	endtask

	// Stop offering and wait until every expected transaction has come back.
	task automatic wait_drained();
		if (offering) begin
			sample.valid <= 1'b0;
			offering = 1'b0;
			@(posedge clk);
		end
		while (stats_expected.size() != 0)
			@(posedge clk);
	endtask

	// Limit writes happen only with the block idle.
	task automatic set_limit(dur_t ns);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= ns;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		limit_ns = ns;
		n_limits++;
	endtask

	// Clear, then exactly enough samples to finish the warm-up.
	task automatic warm_up(dur_t scale);
		send_item(CMD_CLEAR, '0);
		repeat (WarmupSamples) send_item(CMD_RECORD, jitter_dur(scale));
	endtask

	// ------------------------------------------------------------------
	// Test tasks
	// ------------------------------------------------------------------

	// Field extremes and clears while still warming up (limit at reset value).
	task automatic test_warmup_extremes();
		send_item(CMD_RECORD, '0);
		send_item(CMD_RECORD, DurMax);
		send_item(CMD_RECORD, 40'd1);
		send_item(CMD_RECORD, 40'h55_5555_5555);
		send_item(CMD_RECORD, 40'hAA_AAAA_AAAA);
		send_item(CMD_RECORD, 40'h80_0000_0000);
		send_item(CMD_CLEAR, DurMax);   // duration ignored on clear
		send_item(CMD_RECORD, DurMax);
		send_item(CMD_CLEAR, '0);
		send_item(CMD_CLEAR, 40'h12_3456_789A);
	endtask

	// Twice-average rule, from a zero limit and from just below half a ms.
	task automatic test_twice_average();
		set_limit('0);
		warm_up(40'd1000);
		send_item(CMD_RECORD, 40'd2000);
		send_item(CMD_RECORD, 40'd3000);
		send_item(CMD_RECORD, DurMax);
		send_item(CMD_RECORD, '0);
		send_item(CMD_RECORD, 40'd1);
		set_limit(HalfMsNs - 1'b1);
		warm_up(40'd1000);
		send_item(CMD_RECORD, 40'd5000);
		send_item(CMD_RECORD, DurMax);
	endtask

	// Fixed limit just above half a ms and at the top of the range.
	task automatic test_fixed_limit();
		set_limit(HalfMsNs + 1'b1);
		warm_up(40'd400000);
		send_item(CMD_RECORD, HalfMsNs + 1'b1);  // equal: not above
		send_item(CMD_RECORD, HalfMsNs + 2'd2);
		send_item(CMD_RECORD, DurMax);
		send_item(CMD_RECORD, '0);
		// a clear must keep the limit
		warm_up(40'd400000);
		send_item(CMD_RECORD, HalfMsNs + 2'd2);
		set_limit(DurMax);
		warm_up(DurMax);
		send_item(CMD_RECORD, DurMax);
		send_item(CMD_RECORD, DurMax - 1'b1);
	endtask

	// Limit of exactly half a ms: no rule applies.
	task automatic test_half_ms_limit();
		set_limit(HalfMsNs);
		warm_up(40'd10);
		send_item(CMD_RECORD, DurMax);
		send_item(CMD_RECORD, 40'd1000000);
		send_item(CMD_RECORD, '0);
	endtask

	// Receiver holds off long while the sender keeps offering, then the
	// sender waits for every result.
	task automatic test_output_backpressure();
		set_limit('0);
		warm_up(40'd5000);
		hold_request = 400;
		steady = 1'b1;
		repeat (8) send_item(CMD_RECORD, jitter_dur(40'd5000));
		steady = 1'b0;
		wait_drained();
	endtask

	// Random sequences: mostly clear plus a full warm-up and more, some cut
	// short, with stray clears inside and limit changes between sequences.
	task automatic test_random_sequences();
		int unsigned start;
		int unsigned length;
		dur_t        scale;
		start = n_sent;
		while (n_sent - start < RandomItems) begin
			scale = pick_scale();
			if ($urandom_range(9, 0) < 4) begin
				case ($urandom_range(6, 0))
					0:       set_limit('0);
					1:       set_limit(HalfMsNs - 1'b1);
					2:       set_limit(HalfMsNs);
					3:       set_limit(HalfMsNs + 1'b1);
					4:       set_limit(DurMax);
					5:       set_limit(rand_dur());
					default: set_limit(jitter_dur(scale));
				endcase
			end
			if ($urandom_range(4, 0) == 0)
				hold_request = $urandom_range(300, 100);
			if ($urandom_range(9, 0) != 0)
				send_item(CMD_CLEAR, rand_dur());
			length = ($urandom_range(9, 0) < 7) ? $urandom_range(140, 61)
			                                    : $urandom_range(60, 0);
			repeat (length) begin
				if ($urandom_range(49, 0) == 0)
					send_item(CMD_CLEAR, rand_dur());
				else
					send_item(CMD_RECORD, jitter_dur(scale));
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Stats receiver: changes its stall style every so often and honors
	// long hold requests, counting them down itself.
	// ------------------------------------------------------------------
	initial begin : stats_receiver
		int unsigned hold_left;
		int unsigned mode_left;
		int unsigned phase;
		rx_mode_t    mode;
		hold_left = 0;
		mode_left = 0;
		phase     = 0;
		mode      = RX_STEADY;
		stats.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (mode_left == 0) begin
				mode      = rx_mode_t'($urandom_range(2, 0));
				mode_left = $urandom_range(200, 40);
			end
			mode_left--;
			phase++;
			if (hold_left != 0) begin
				hold_left--;
				stats.ready <= 1'b0;
			end else begin
				case (mode)
					RX_STEADY: stats.ready <= 1'b1;
					RX_RANDOM: stats.ready <= 1'($urandom_range(1, 0));
					default:   stats.ready <= (phase % 5) < 2;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Result check: outputs are stable around the falling edge, so a
	// transaction seen there is the one taken at the next rising edge.
	// ------------------------------------------------------------------
	function automatic void compare_field(string field, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endfunction

	initial begin : stats_checker
		stats_t want;
		forever begin
			@(negedge clk);
			if (arst_n && stats.valid && stats.ready) begin
				if (stats_expected.size() == 0) begin
					mismatches++;
					$display("%0t: stats transaction with none expected, actual echo %0d",
						$time, stats.elapsed_echo_ns);
				end else begin
					want = stats_expected.pop_front();
					n_checked++;
					compare_field("elapsed_echo_ns", want.echo_ns, stats.elapsed_echo_ns);
					compare_field("sample_count", want.count, stats.sample_count);
					compare_field("average_ns", want.average_ns, stats.average_ns);
					compare_field("above_flag", want.above, stats.above_flag);
					compare_field("above_count", want.above_count, stats.above_count);
					compare_field("above_average_ns", want.above_average_ns,
						stats.above_average_ns);
					compare_field("above_max_ns", want.above_max_ns, stats.above_max_ns);
				end
			end
		end
	end

	// Watchdog: a hung block ends the run here.
	initial begin : watchdog
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout after %0d cycles, %0d results outstanding",
			$time, cycle_count, stats_expected.size());
		$display("FAIL latency_statistics_tracker");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main_sequence
		arst_n            <= 1'b0;
		cfg_wr_en         <= 1'b0;
		cfg_wr_data       <= '0;
		sample.valid      <= 1'b0;
		sample.command    <= CMD_RECORD;
		sample.elapsed_ns <= '0;
		drop_statistics();
		burst_left = $urandom_range(24, 1);
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_warmup_extremes();
		test_twice_average();
		test_fixed_limit();
		test_half_ms_limit();
		test_output_backpressure();
		test_random_sequences();

		// all results in, then a quiet spell to catch stray transactions
		wait_drained();
		repeat (SettleCycles) @(posedge clk);

		$display("Sent %0d transactions (%0d clears), checked %0d results, %0d outliers.",
			n_sent, n_clears, n_checked, n_flagged);
		$display("Used %0d limit writes over %0d cycles; %0d mismatches.",
			n_limits, cycle_count, mismatches);
		if (mismatches == 0)
			$display("PASS latency_statistics_tracker");
		else
			$display("FAIL latency_statistics_tracker");
		$finish;
	end

endmodule
